>>> rtl/rcwt_pkg.sv
// shared types and constants for the raycast wall column texturer
// no dependencies
package rcwt_pkg;

  // configuration register indexes
  localparam logic CFG_ROW_SHIFT  = 1'b0;
  localparam logic CFG_EYE_OFFSET = 1'b1;

  // request kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // divider sizes: dividend and divisor widths
  localparam int unsigned DIV_W = 36;
  localparam int unsigned DVS_W = 17;

  typedef struct packed {
    logic               mode;
    logic [7:0]         column;
    logic [15:0]        distance;
    logic               hit_side;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic               texture_select;
    logic [11:0]        texel_address;
    logic [31:0]        texel;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [7:0]  out_column;
    logic [31:0] color;
    logic [15:0] depth;
    logic        last;
  } out_item_t;

  // classified request held in the queue
  typedef struct packed {
    logic               is_load;
    logic               sel;
    logic [11:0]        addr;
    logic [31:0]        texel;
    logic [7:0]         column;
    logic [15:0]        distance;
    logic [15:0]        pos;
    logic signed [15:0] dir;
  } cmd_t;

  // divider start request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/raycast_wall_column_texturer.sv
// top level of the raycast wall column texturer
// depends on rcwt_pkg, rcwt_front, rcwt_fifo, rcwt_back
//
// A load request writes one texel. A draw request runs three divisions on
// one shared bit-serial divider (line height, start row, texture step), plus
// setup steps, then emits one pixel write per visible row at one per cycle
// while the output is not stalled. A two-entry queue lets the next requests
// be taken while a column is drawn.
module raycast_wall_column_texturer #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned TEX_SIZE      = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcwt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcwt_pkg::out_item_t out_data_o
);
  import rcwt_pkg::*;

  logic signed [7:0] row_shift_q;
  logic signed [7:0] eye_offset_q;
  logic              push, pop, q_full, q_empty;
  cmd_t              push_cmd, pop_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_shift_q  <= '0;
      eye_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_SHIFT:  row_shift_q  <= cfg_data_i;
        CFG_EYE_OFFSET: eye_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcwt_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
    .item_i   (in_data_i),
    .valid_i  (in_valid_i),
    .q_full_i (q_full),
    .stall_o  (in_stall_o),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  rcwt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rcwt_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .TEX_SIZE(TEX_SIZE)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_shift_i  (row_shift_q),
    .eye_offset_i (eye_offset_q),
    .q_empty_i    (q_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> rtl/rcwt_front.sv
// front end: takes requests and classifies them into queue commands
// depends on rcwt_pkg
module rcwt_front #(
  parameter int unsigned SCREEN_WIDTH = 256
) (
  input  rcwt_pkg::in_item_t item_i,
  input  logic               valid_i,
  input  logic               q_full_i,
  output logic               stall_o,
  output logic               push_o,
  output rcwt_pkg::cmd_t     cmd_o
);
  import rcwt_pkg::*;

  logic on_screen;
  logic is_load;

  // off-screen draw columns are dropped here
  assign on_screen = {1'b0, item_i.column} < 9'(SCREEN_WIDTH);
  assign is_load   = (item_i.mode == MODE_LOAD);

  // clamp distance, pick the position and direction axis for the hit side
  always_comb begin
    cmd_o.is_load  = is_load;
    cmd_o.sel      = is_load ? item_i.texture_select : item_i.hit_side;
    cmd_o.addr     = item_i.texel_address;
    cmd_o.texel    = item_i.texel;
    cmd_o.column   = item_i.column;
    cmd_o.distance = (item_i.distance == 16'd0) ? 16'd1 : item_i.distance;
    cmd_o.pos      = item_i.hit_side ? item_i.pos_x : item_i.pos_y;
    cmd_o.dir      = item_i.hit_side ? item_i.dir_x : item_i.dir_y;
  end

  assign stall_o = q_full_i;
  assign push_o  = valid_i && !q_full_i && (is_load || on_screen);

endmodule

>>> rtl/rcwt_fifo.sv
// two-entry command queue between front and back end
// depends on rcwt_pkg
module rcwt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcwt_pkg::cmd_t data_i,
  input  logic           pop_i,
  output rcwt_pkg::cmd_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import rcwt_pkg::*;

  cmd_t       entry_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wp_q] <= data_i;
  end

  assign data_o  = entry_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

>>> rtl/rcwt_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on rcwt_pkg
module rcwt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rcwt_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [rcwt_pkg::DIV_W-1:0]  quot_o
);
  import rcwt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // one restoring step
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[DVS_W+1];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/rcwt_back.sv
// back end: column setup sequencer, texture memory and pixel output stage
// depends on rcwt_pkg and rcwt_div
module rcwt_back #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned TEX_SIZE      = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [7:0]   row_shift_i,
  input  logic signed [7:0]   eye_offset_i,
  input  logic                q_empty_i,
  input  rcwt_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcwt_pkg::out_item_t out_data_o
);
  import rcwt_pkg::*;

  localparam int unsigned TW   = $clog2(TEX_SIZE);
  localparam int unsigned TP_W = 16 + TW;
  localparam int unsigned RW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned LH_NUM   = 2 * SCREEN_HEIGHT * 256;
  localparam int unsigned STEP_NUM = TEX_SIZE * 65536;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LH   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_TOP  = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_INIT = 3'd6;
  localparam logic [2:0] S_ROW  = 3'd7;

  logic [2:0]          state_q, state_d;
  cmd_t                cmd_q;
  logic [16:0]         lh_q;
  logic signed [32:0]  prod_q;
  logic [TW-1:0]       texx_q;
  logic signed [35:0]  num_q;
  logic                neg_q;
  logic [5:0]          topc_q;
  logic [16:0]         clip_q;
  logic [RW-1:0]       n_q;
  logic [TP_W-1:0]     step_q;
  logic [TP_W-1:0]     tpos_q;
  logic [RW-1:0]       k_q;

  logic [31:0]         tex_mem [8192];
  logic [31:0]         rd_q;

  logic                p_valid_q;
  logic [5:0]          p_row_q;
  logic                p_last_q;
  logic [7:0]          p_col_q;
  logic [15:0]         p_depth_q;
  out_item_t           o_q;
  logic                o_valid_q;

  div_req_t            div_req;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;

  logic signed [17:0]  diff_hl;
  logic signed [18:0]  a_w;
  logic signed [35:0]  mul_w;
  logic signed [35:0]  eye_w;
  logic [21:0]         frac_w;
  logic signed [19:0]  qt_w;
  logic signed [19:0]  top_w;
  logic [16:0]         clip_w;
  logic signed [18:0]  vis_w;
  logic [5:0]          topc_w;
  logic [RW-1:0]       room_w;
  logic [RW-1:0]       n_w;
  logic                skip_w;
  logic [16+TP_W-1:0]  tpos0_w;
  logic                o_free, p_move, issue, last_row;
  logic                mem_we;
  logic [12:0]         rd_addr;
  logic [TW-1:0]       ty_w;

  rcwt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // start row: floor((H - lh) / 2) + row shift, then times distance plus eye offset times 256
  assign diff_hl = $signed(18'(SCREEN_HEIGHT)) - $signed({1'b0, lh_q});
  assign a_w     = 19'(diff_hl >>> 1) + 19'(row_shift_i);
  assign mul_w   = a_w * $signed({1'b0, cmd_q.distance});
  assign eye_w   = 36'(eye_offset_i);

  // wall hit fraction, only the low 22 bits matter
  assign frac_w = 22'(prod_q) + {cmd_q.pos[7:0], 14'd0};

  // signed truncating quotient and clipping
  assign qt_w   = {1'b0, div_quot[18:0]};
  assign top_w  = neg_q ? -qt_w : qt_w;
  assign clip_w = top_w[19] ? 17'(-top_w) : 17'd0;
  assign vis_w  = $signed({2'b00, lh_q}) - $signed({2'b00, clip_w});
  assign skip_w = (vis_w <= 19'sd0) || (top_w >= $signed(20'(SCREEN_HEIGHT)));
  assign topc_w = top_w[19] ? 6'd0 : top_w[5:0];
  assign room_w = RW'(SCREEN_HEIGHT) - RW'(topc_w);
  assign n_w    = (vis_w < $signed({{(19 - RW){1'b0}}, room_w})) ? RW'(vis_w) : room_w;

  assign tpos0_w = clip_q * step_q;

  // row pipeline handshakes
  assign o_free   = !o_valid_q || !out_stall_i;
  assign p_move   = p_valid_q && o_free;
  assign issue    = (state_q == S_ROW) && (!p_valid_q || p_move);
  assign last_row = (k_q == n_q - RW'(1));
  assign ty_w     = tpos_q[16 +: TW];
  assign rd_addr  = {cmd_q.sel, 12'({ty_w, texx_q})};

  assign pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign mem_we = pop_o && cmd_i.is_load;

  // sequencer next state and divider requests
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(LH_NUM);
    div_req.divisor  = {1'b0, cmd_i.distance};
    unique case (state_q)
      S_IDLE: begin
        if (pop_o && !cmd_i.is_load) begin
          div_req.start = 1'b1;
          state_d       = S_LH;
        end
      end
      S_LH: begin
        if (div_done) state_d = S_MUL;
      end
      S_MUL: state_d = S_NUM;
      S_NUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = neg_q ? DIV_W'(-num_q) : DIV_W'(num_q);
        div_req.divisor  = {1'b0, cmd_q.distance};
        state_d          = S_TOP;
      end
      S_TOP: begin
        if (div_done) begin
          if (skip_w) begin
            state_d = S_IDLE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(STEP_NUM);
            div_req.divisor  = lh_q;
            state_d          = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (div_done) state_d = S_INIT;
      end
      S_INIT: state_d = S_ROW;
      S_ROW: begin
        if (issue && last_row) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) p_valid_q <= 1'b1;
      else if (p_move) p_valid_q <= 1'b0;
      if (p_move) o_valid_q <= 1'b1;
      else if (!out_stall_i) o_valid_q <= 1'b0;
    end
  end

  // column setup datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (state_q == S_LH) begin
      prod_q <= cmd_q.dir * $signed({1'b0, cmd_q.distance});
      if (div_done) lh_q <= div_quot[16:0] + 17'd4;
    end
    if (state_q == S_MUL) begin
      num_q  <= mul_w + (eye_w <<< 8);
      neg_q  <= mul_w + (eye_w <<< 8) < 36'sd0;
      texx_q <= frac_w[21 -: TW];
    end
    if (state_q == S_TOP && div_done) begin
      topc_q <= topc_w;
      clip_q <= clip_w;
      n_q    <= n_w;
    end
    if (state_q == S_STEP && div_done) step_q <= div_quot[TP_W-1:0];
    if (state_q == S_INIT) begin
      tpos_q <= tpos0_w[TP_W-1:0];
      k_q    <= '0;
    end else if (issue) begin
      tpos_q <= tpos_q + step_q;
      k_q    <= k_q + RW'(1);
    end
  end

  // texture memory
  always_ff @(posedge clk_i) begin
    if (mem_we) tex_mem[{cmd_i.sel, cmd_i.addr}] <= cmd_i.texel;
    if (issue) rd_q <= tex_mem[rd_addr];
  end

  // read stage and output register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_row_q   <= topc_q + 6'(k_q);
      p_last_q  <= last_row;
      p_col_q   <= cmd_q.column;
      p_depth_q <= cmd_q.distance;
    end
    if (p_move) begin
      o_q.row        <= p_row_q;
      o_q.out_column <= p_col_q;
      o_q.color      <= rd_q;
      o_q.depth      <= p_depth_q;
      o_q.last       <= p_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

endmodule

>>> rtl/rcwt_checker.sv
// port-level checks for the raycast wall column texturer, bound to the top
// depends on rcwt_pkg
module rcwt_checker #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned SCREEN_WIDTH  = 256
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rcwt_pkg::out_item_t out_data_o
);
  import rcwt_pkg::*;

  // stalled pixel write holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("pixel write changed while stalled");

  // depth is clamped to at least one lsb
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.depth != 16'd0)
    else $error("zero depth written");

  // rows stay on screen
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 7'(out_data_o.row) < 7'(SCREEN_HEIGHT))
    else $error("row below screen");

  // columns stay on screen
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_data_o.out_column} < 9'(SCREEN_WIDTH))
    else $error("column off screen");

endmodule

bind raycast_wall_column_texturer rcwt_checker #(
  .SCREEN_HEIGHT(SCREEN_HEIGHT),
  .SCREEN_WIDTH (SCREEN_WIDTH)
) u_rcwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
